// ----- rtl/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// shared types, codes and defaults of the first-fit heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int ALIGN_BYTES_DEF  = 16;
  localparam int HEADER_BYTES_DEF = 16;

  localparam int LW = 25;  // block offset and length width
  localparam int NW = 27;  // width of need and growth arithmetic

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_MEMORY   = 3'd1;
  localparam logic [2:0] ST_MISALIGNED  = 3'd2;
  localparam logic [2:0] ST_NOT_BLOCK   = 3'd3;
  localparam logic [2:0] ST_DOUBLE_FREE = 3'd4;

  localparam logic [1:0] REG_HEAP_BASE    = 2'd0;
  localparam logic [1:0] REG_HEAP_SIZE    = 2'd1;
  localparam logic [1:0] REG_HEAP_LIMIT   = 2'd2;
  localparam logic [1:0] REG_GROW_GRANULE = 2'd3;

  localparam logic [31:0] HEAP_BASE_RST    = 32'd0;
  localparam logic [24:0] HEAP_SIZE_RST    = 25'd65536;
  localparam logic [24:0] HEAP_LIMIT_RST   = 25'd1048576;
  localparam logic [16:0] GROW_GRANULE_RST = 17'd4096;

  typedef enum logic [4:0] {
    OP_NOP, OP_INIT, OP_START, OP_RD_IDX, OP_SCAN_NEXT, OP_RD_LAST, OP_GROW,
    OP_TAKE, OP_SHIFT_RD, OP_SHIFT_WR, OP_SPLIT_A, OP_SPLIT_B, OP_MARK,
    OP_MERGE_RD, OP_MERGE_ADD, OP_MERGE_WR, OP_COPY_RD, OP_COPY_WR, OP_COMPACT,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] code;
    logic       with_addr;
  } cmd_t;

  typedef struct packed {
    logic init_req;
    logic is_free;
    logic addr_null;
    logic addr_misaligned;
    logic scan_done;
    logic hit;
    logic grow_fail;
    logic short_block;
    logic split_ok;
    logic shift_more;
    logic used_idx;
    logic merge_more;
    logic copy_more;
  } sts_t;

endpackage

// ----- rtl/ffha_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffha_ctrl
// request sequencer: scan, grow, split, merge and compaction steps
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ffha_pkg::sts_t sts,
  output ffha_pkg::cmd_t cmd
);
  import ffha_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE       = 17'h00001,
    S_DISPATCH   = 17'h00002,
    S_SCAN_RD    = 17'h00004,
    S_SCAN_CHK   = 17'h00008,
    S_GROW       = 17'h00010,
    S_GROW_CHK   = 17'h00020,
    S_SPLIT_TEST = 17'h00040,
    S_SH_WR      = 17'h00080,
    S_SPLIT_B    = 17'h00100,
    S_MARK       = 17'h00200,
    S_FREE_CHK   = 17'h00400,
    S_MERGE_TEST = 17'h00800,
    S_MERGE_ADD  = 17'h01000,
    S_COPY_TEST  = 17'h02000,
    S_COPY_WR    = 17'h04000,
    S_RES        = 17'h08000,
    S_SPARE      = 17'h10000
  } state_t;

  state_t     state, state_next;
  logic [2:0] res_code, res_code_next;
  logic       res_addr, res_addr_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && !sts.init_req;

  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    res_addr_next = res_addr;
    cmd           = '{op: OP_NOP, code: res_code, with_addr: res_addr};
    case (state)
      S_IDLE: begin
        if (sts.init_req) begin
          cmd.op = OP_INIT;
        end else if (in_valid) begin
          cmd.op     = OP_START;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_addr_next = 1'b0;
        if (sts.is_free && sts.addr_null) begin
          res_code_next = ST_OK;
          state_next    = S_RES;
        end else if (sts.is_free && sts.addr_misaligned) begin
          res_code_next = ST_MISALIGNED;
          state_next    = S_RES;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts.scan_done && sts.is_free) begin
          res_code_next = ST_NOT_BLOCK;
          state_next    = S_RES;
        end else if (sts.scan_done) begin
          cmd.op     = OP_RD_LAST;
          state_next = S_GROW;
        end else begin
          cmd.op     = OP_RD_IDX;
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (sts.hit) begin
          cmd.op     = OP_TAKE;
          state_next = sts.is_free ? S_FREE_CHK : S_SPLIT_TEST;
        end else begin
          cmd.op     = OP_SCAN_NEXT;
          state_next = S_SCAN_RD;
        end
      end
      S_GROW: begin
        if (sts.grow_fail) begin
          res_code_next = ST_NO_MEMORY;
          state_next    = S_RES;
        end else begin
          cmd.op     = OP_GROW;
          state_next = S_GROW_CHK;
        end
      end
      S_GROW_CHK: begin
        if (sts.short_block) begin
          res_code_next = ST_NO_MEMORY;
          state_next    = S_RES;
        end else begin
          state_next = S_SPLIT_TEST;
        end
      end
      S_SPLIT_TEST: begin
        if (!sts.split_ok) begin
          state_next = S_MARK;
        end else if (sts.shift_more) begin
          cmd.op     = OP_SHIFT_RD;
          state_next = S_SH_WR;
        end else begin
          cmd.op     = OP_SPLIT_A;
          state_next = S_SPLIT_B;
        end
      end
      S_SH_WR: begin
        cmd.op     = OP_SHIFT_WR;
        state_next = S_SPLIT_TEST;
      end
      S_SPLIT_B: begin
        cmd.op     = OP_SPLIT_B;
        state_next = S_MARK;
      end
      S_MARK: begin
        cmd.op        = OP_MARK;
        res_code_next = ST_OK;
        res_addr_next = 1'b1;
        state_next    = S_RES;
      end
      S_FREE_CHK: begin
        if (!sts.used_idx) begin
          res_code_next = ST_DOUBLE_FREE;
          state_next    = S_RES;
        end else begin
          state_next = S_MERGE_TEST;
        end
      end
      S_MERGE_TEST: begin
        if (sts.merge_more) begin
          cmd.op     = OP_MERGE_RD;
          state_next = S_MERGE_ADD;
        end else begin
          cmd.op     = OP_MERGE_WR;
          state_next = S_COPY_TEST;
        end
      end
      S_MERGE_ADD: begin
        cmd.op     = OP_MERGE_ADD;
        state_next = S_MERGE_TEST;
      end
      S_COPY_TEST: begin
        if (sts.copy_more) begin
          cmd.op     = OP_COPY_RD;
          state_next = S_COPY_WR;
        end else begin
          cmd.op        = OP_COMPACT;
          res_code_next = ST_OK;
          state_next    = S_RES;
        end
      end
      S_COPY_WR: begin
        cmd.op     = OP_COPY_WR;
        state_next = S_COPY_TEST;
      end
      S_RES: begin
        if (slot_free) begin
          cmd.op     = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      res_code  <= ST_OK;
      res_addr  <= 1'b0;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
      res_addr <= res_addr_next;
      if (cmd.op == OP_RESULT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/ffha_dp.sv -----
// ----------------------------------------------------------------------------
// ffha_dp
// block table memory, used marks, config registers and request arithmetic
// ----------------------------------------------------------------------------
module ffha_dp #(
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  ffha_pkg::cmd_t cmd,
  output ffha_pkg::sts_t sts,
  input  logic           req_type,
  input  logic [23:0]    req_size,
  input  logic [31:0]    free_address,
  input  logic           cfg_valid,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  output logic [2:0]     status,
  output logic [31:0]    data_address
);
  import ffha_pkg::*;

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int AB = $clog2(ALIGN_BYTES);

  logic [31:0]   heap_base;
  logic [LW-1:0] heap_size, heap_limit, heap_end;
  logic [16:0]   grow_granule;
  logic          init_req;

  logic [LW-1:0] mem_off [MAX_BLOCKS];
  logic [LW-1:0] mem_len [MAX_BLOCKS];
  logic [LW-1:0] rd_off, rd_len;
  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [LW-1:0] wo, wl;

  logic [MAX_BLOCKS-1:0] used, used_ins;
  logic [CW-1:0] count, idx, jdx, kdx, cm1, jm1, ip1;
  logic [AW-1:0] idx_a, jdx_a, kdx_a;
  logic          req_free;
  logic [31:0]   free_addr;
  logic [NW-1:0] need, need_comb, inc, inc_comb, gran, he_sum;
  logic [LW-1:0] cur_off, cur_len, sum;
  logic [31:0]   match_addr;

  assign idx_a = idx[AW-1:0];
  assign jdx_a = jdx[AW-1:0];
  assign kdx_a = kdx[AW-1:0];
  assign cm1   = count - CW'(1);
  assign jm1   = jdx - CW'(1);
  assign ip1   = idx + CW'(1);

  assign need_comb = (NW'(req_size) + NW'(HEADER_BYTES) + NW'(ALIGN_BYTES - 1))
                     & ~NW'(ALIGN_BYTES - 1);
  assign gran      = NW'(grow_granule);
  assign inc_comb  = (grow_granule == 17'd0) ? need
                     : ((need + gran - NW'(1)) & ~(gran - NW'(1)));
  assign he_sum    = NW'(heap_end) + inc;
  assign match_addr = heap_base + 32'(rd_off) + 32'(HEADER_BYTES);

  always_comb begin
    used_ins = used;
    for (int j = 0; j < MAX_BLOCKS; j++) begin
      if (CW'(j) > ip1) begin
        used_ins[j] = used[(j > 0) ? j - 1 : 0];
      end else if (CW'(j) == ip1) begin
        used_ins[j] = 1'b0;
      end
    end
  end

  always_comb begin
    sts.init_req        = init_req;
    sts.is_free         = req_free;
    sts.addr_null       = (free_addr == 32'd0);
    sts.addr_misaligned = (free_addr[AB-1:0] != '0);
    sts.scan_done       = (idx >= count);
    sts.hit             = req_free ? (match_addr == free_addr)
                          : (!used[idx_a] && (NW'(rd_len) >= need));
    sts.grow_fail       = (he_sum > NW'(heap_limit))
                          || (used[idx_a] && (count >= CW'(MAX_BLOCKS)));
    sts.short_block     = (NW'(cur_len) < need);
    sts.split_ok        = ({1'b0, NW'(cur_len)} > {need, 1'b0})
                          && (count < CW'(MAX_BLOCKS));
    sts.shift_more      = ({1'b0, jdx} > {1'b0, ip1});
    sts.used_idx        = used[idx_a];
    sts.merge_more      = (jdx < count) && !used[jdx_a];
    sts.copy_more       = (jdx < count);
  end

  always_comb begin
    we = 1'b0;
    re = 1'b0;
    wa = idx_a;
    ra = idx_a;
    wo = rd_off;
    wl = rd_len;
    case (cmd.op)
      OP_INIT: begin
        we = 1'b1;
        wa = '0;
        wo = '0;
        wl = heap_size;
      end
      OP_RD_IDX: begin
        re = 1'b1;
      end
      OP_RD_LAST: begin
        re = 1'b1;
        ra = cm1[AW-1:0];
      end
      OP_GROW: begin
        we = 1'b1;
        if (used[idx_a]) begin
          wa = count[AW-1:0];
          wo = heap_end;
          wl = inc[LW-1:0];
        end else begin
          wl = rd_len + inc[LW-1:0];
        end
      end
      OP_SHIFT_RD: begin
        re = 1'b1;
        ra = jm1[AW-1:0];
      end
      OP_SHIFT_WR: begin
        we = 1'b1;
        wa = jdx_a;
      end
      OP_SPLIT_A: begin
        we = 1'b1;
        wo = cur_off;
        wl = need[LW-1:0];
      end
      OP_SPLIT_B: begin
        we = 1'b1;
        wa = ip1[AW-1:0];
        wo = cur_off + need[LW-1:0];
        wl = cur_len - need[LW-1:0];
      end
      OP_MERGE_RD, OP_COPY_RD: begin
        re = 1'b1;
        ra = jdx_a;
      end
      OP_MERGE_WR: begin
        we = 1'b1;
        wo = cur_off;
        wl = sum;
      end
      OP_COPY_WR: begin
        we = 1'b1;
        wa = kdx_a;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_off[wa] <= wo;
      mem_len[wa] <= wl;
    end
    if (re) begin
      rd_off <= mem_off[ra];
      rd_len <= mem_len[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base    <= HEAP_BASE_RST;
      heap_size    <= HEAP_SIZE_RST;
      heap_limit   <= HEAP_LIMIT_RST;
      grow_granule <= GROW_GRANULE_RST;
      init_req     <= 1'b1;
      count        <= CW'(1);
      heap_end     <= HEAP_SIZE_RST;
      used         <= '0;
      req_free     <= 1'b0;
      status       <= ST_OK;
      data_address <= '0;
    end else begin
      case (cmd.op)
        OP_INIT: begin
          count    <= CW'(1);
          heap_end <= heap_size;
          used     <= '0;
          init_req <= 1'b0;
        end
        OP_START: begin
          req_free  <= req_type;
          need      <= need_comb;
          free_addr <= free_address;
          idx       <= '0;
        end
        OP_SCAN_NEXT: begin
          idx <= idx + CW'(1);
        end
        OP_RD_LAST: begin
          idx <= cm1;
          inc <= inc_comb;
        end
        OP_GROW: begin
          heap_end <= he_sum[LW-1:0];
          if (used[idx_a]) begin
            cur_off <= heap_end;
            cur_len <= inc[LW-1:0];
            idx     <= count;
            count   <= count + CW'(1);
            jdx     <= count + CW'(1);
          end else begin
            cur_off <= rd_off;
            cur_len <= rd_len + inc[LW-1:0];
            jdx     <= count;
          end
        end
        OP_TAKE: begin
          cur_off <= rd_off;
          cur_len <= rd_len;
          sum     <= rd_len;
          jdx     <= req_free ? ip1 : count;
        end
        OP_SHIFT_WR: begin
          jdx <= jm1;
        end
        OP_SPLIT_B: begin
          count <= count + CW'(1);
          used  <= used_ins;
        end
        OP_MARK: begin
          used[idx_a] <= 1'b1;
        end
        OP_MERGE_ADD: begin
          sum <= sum + rd_len;
          jdx <= jdx + CW'(1);
        end
        OP_MERGE_WR: begin
          used[idx_a] <= 1'b0;
          kdx         <= ip1;
        end
        OP_COPY_WR: begin
          used[kdx_a] <= used[jdx_a];
          kdx         <= kdx + CW'(1);
          jdx         <= jdx + CW'(1);
        end
        OP_COMPACT: begin
          count <= kdx;
        end
        OP_RESULT: begin
          status       <= cmd.code;
          data_address <= cmd.with_addr
                          ? (heap_base + 32'(cur_off) + 32'(HEADER_BYTES)) : 32'd0;
        end
        default: begin
          count <= count;
        end
      endcase
      if (cfg_valid) begin
        case (cfg_index)
          REG_HEAP_BASE:    heap_base <= cfg_data;
          REG_HEAP_SIZE: begin
            heap_size <= cfg_data[LW-1:0];
            init_req  <= 1'b1;
          end
          REG_HEAP_LIMIT:   heap_limit <= cfg_data[LW-1:0];
          REG_GROW_GRANULE: grow_granule <= cfg_data[16:0];
          default:          heap_base <= heap_base;
        endcase
      end
    end
  end

endmodule

// ----- rtl/first_fit_heap_allocator_core.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// first-fit heap allocator over a table of blocks in address order
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one result. The block table sits
// in a memory with separate write and read ports and a registered read. An
// allocate scans to the first fitting block, grows the heap at its end when
// none fits, and moves the later entries up one place when a block is split;
// a free searches the table for the address, merges the free entries after it
// and moves the entries behind them down. After reset and after each write of
// heap_size the table is rebuilt before the next request is taken. Parameters
// ALIGN_BYTES must be a power of two, and grow_granule is treated as a power
// of two (zero means one).
module first_fit_heap_allocator_core #(
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [23:0] req_size,
  input  logic [31:0] free_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] data_address,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ffha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffha_dp #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .ALIGN_BYTES  (ALIGN_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (req_type),
    .req_size     (req_size),
    .free_address (free_address),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .status       (status),
    .data_address (data_address)
  );

endmodule

// ----- rtl/ffha_checker.sv -----
// ----------------------------------------------------------------------------
// ffha_checker
// port-level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
module ffha_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] data_address
);
  import ffha_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(data_address))
    else $error("result changed while stalled");

  // failed transaction never carries an address
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> data_address == 32'd0)
    else $error("address on failed transaction");

  // status code is in range
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_NO_MEMORY || status == ST_MISALIGNED
      || status == ST_NOT_BLOCK || status == ST_DOUBLE_FREE)
    else $error("bad status code");

  // one transaction at a time
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted while busy");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .data_address (data_address)
);
